// File: hdl/p2a_pkg.sv
// Shared types and constants for the pixel to ASCII art downscaler.
package p2a_pkg;

	// Frame geometry
	localparam int DIM_W     = 13;
	localparam int CFG_IDX_W = 2;
	localparam logic [DIM_W-1:0] MAX_WIDTH      = 13'd4096;
	localparam logic [DIM_W-1:0] MAX_HEIGHT     = 13'd4096;
	localparam logic [DIM_W-1:0] DEFAULT_TARGET = 13'd80;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET_WIDTH = 2'd2;

	// Payload widths
	localparam int RGB_W   = 24;
	localparam int CHAR_W  = 7;
	localparam int CLASS_W = 4;

	// Shared divider: width / target, then height * target / (2 * width)
	localparam int DIV_NUM_W = 25;
	localparam int DIV_DEN_W = 14;
	localparam int DIV_CNT_W = 5;

	// Queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	// One kept pixel on its way to the back end
	typedef struct packed {
		logic [RGB_W-1:0] rgb;
		logic             eor;
		logic             eof;
	} item_t;

	typedef struct packed {
		logic                 start;
		logic [DIV_NUM_W-1:0] num;
		logic [DIV_DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic                 done;
		logic [DIV_NUM_W-1:0] quot;
		logic [DIV_DEN_W-1:0] rem;
	} div_rsp_t;

endpackage

// File: hdl/p2a_div.sv
// Restoring divider, one quotient bit per cycle, shared by the frame setup.
module p2a_div (
	input  logic                clk,
	input  logic                arst_n,
	input  p2a_pkg::div_req_t   req,
	output p2a_pkg::div_rsp_t   rsp
);

	logic                           busy_q;
	logic                           done_q;
	logic [p2a_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic [p2a_pkg::DIV_NUM_W-1:0]  quo_q;
	logic [p2a_pkg::DIV_DEN_W-1:0]  rem_q;
	logic [p2a_pkg::DIV_DEN_W-1:0]  den_q;
	logic [p2a_pkg::DIV_DEN_W:0]    trial;
	logic [p2a_pkg::DIV_DEN_W:0]    diff;
	logic                           ge;

	// Trial subtract of the next partial remainder
	always_comb begin
		trial = {rem_q, quo_q[p2a_pkg::DIV_NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		ge    = trial >= {1'b0, den_q};
	end

	// Sequence control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (!busy_q && req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == p2a_pkg::DIV_CNT_W'(p2a_pkg::DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shift quotient bits in, keep the partial remainder
	always_ff @(posedge clk) begin
		if (!busy_q && req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			quo_q <= {quo_q[p2a_pkg::DIV_NUM_W-2:0], ge};
			rem_q <= ge ? diff[p2a_pkg::DIV_DEN_W-1:0] : trial[p2a_pkg::DIV_DEN_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;
	assign rsp.rem  = rem_q;

	// A new division must not start on top of one in flight
	assert property (@(posedge clk) disable iff (!arst_n) req.start |-> !busy_q)
		else $error("divider started while busy");

endmodule

// File: hdl/p2a_queue.sv
// Short queue of kept pixels between the front and back ends.
module p2a_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  p2a_pkg::item_t      push_item,
	output logic                full,
	input  logic                pop,
	output p2a_pkg::item_t      pop_item,
	output logic                avail
);

	p2a_pkg::item_t              entry_q [p2a_pkg::QUEUE_DEPTH];
	logic [p2a_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [p2a_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [p2a_pkg::QCNT_W-1:0]  count_q;

	assign full     = count_q == p2a_pkg::QCNT_W'(p2a_pkg::QUEUE_DEPTH);
	assign avail    = count_q != '0;
	assign pop_item = entry_q[rd_ptr_q];

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the request
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("queue overflow");
	assert property (@(posedge clk) disable iff (!arst_n) pop |-> avail)
		else $error("queue underflow");

endmodule

// File: hdl/p2a_front.sv
// Front end: configuration, frame setup, position tracking and pixel selection.
module p2a_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [p2a_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [p2a_pkg::DIM_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [p2a_pkg::RGB_W-1:0]          pixel_rgb,
	input  logic                               frame_start,
	output p2a_pkg::div_req_t                  div_req,
	input  p2a_pkg::div_rsp_t                  div_rsp,
	output logic                               q_push,
	output p2a_pkg::item_t                     q_item,
	input  logic                               q_full
);

	typedef enum logic [2:0] {
		ST_RUN,
		ST_MUL,
		ST_COLDIV,
		ST_ROWSTART,
		ST_ROWDIV,
		ST_HOLD
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [12:0] img_w_q;
	logic [12:0] img_h_q;
	logic [12:0] tgt_w_q;

	// Frame geometry latched at frame start, and the steps derived from it
	logic        frame_valid_q;
	logic [12:0] fw_q;
	logic [12:0] fh_q;
	logic [12:0] t_q;
	logic [12:0] th_q;
	logic [12:0] cq_q;
	logic [11:0] cr_q;
	logic [13:0] rq_q;
	logic [11:0] rr_q;
	logic [24:0] prod_q;
	logic [p2a_pkg::RGB_W-1:0] hold_rgb_q;

	// Positions
	logic [11:0] in_col_q;
	logic [12:0] in_row_q;
	logic [12:0] out_col_q;
	logic [12:0] out_row_q;
	logic [12:0] cpos_q;
	logic [11:0] cfrac_q;
	logic [13:0] rpos_q;
	logic [11:0] rfrac_q;

	logic [12:0] fw_n;
	logic [12:0] fh_n;
	logic [12:0] tsel;
	logic [12:0] t_n;
	logic [25:0] prod_full;
	logic [p2a_pkg::RGB_W-1:0] cur_rgb;
	logic        accept;
	logic        step;
	logic        active;
	logic        row_kept;
	logic        col_kept;
	logic        last_col;
	logic        row_end;
	logic [12:0] csum;
	logic [12:0] cdiff;
	logic        cwrap;
	logic [12:0] cpos_adv;
	logic [12:0] rsum;
	logic [12:0] rdiff;
	logic        rwrap;
	logic [13:0] rpos_adv;
	logic [12:0] rem2;
	logic [12:0] rdiff0;
	logic        rwrap0;

	// Clamp the geometry for the new frame
	always_comb begin
		if (img_w_q == '0) begin
			fw_n = 13'd1;
		end else if (img_w_q > p2a_pkg::MAX_WIDTH) begin
			fw_n = p2a_pkg::MAX_WIDTH;
		end else begin
			fw_n = img_w_q;
		end
		if (img_h_q == '0) begin
			fh_n = 13'd1;
		end else if (img_h_q > p2a_pkg::MAX_HEIGHT) begin
			fh_n = p2a_pkg::MAX_HEIGHT;
		end else begin
			fh_n = img_h_q;
		end
		tsel = (tgt_w_q == '0) ? p2a_pkg::DEFAULT_TARGET : tgt_w_q;
		t_n  = (tsel > fw_n) ? fw_n : tsel;
	end

	assign prod_full = fh_q * t_q;

	// Classify the current pixel against the next kept row and column
	always_comb begin
		cur_rgb  = (state_q == ST_HOLD) ? hold_rgb_q : pixel_rgb;
		in_ready = (state_q == ST_RUN) && !q_full;
		accept   = in_valid && in_ready;
		step     = (accept && !frame_start) || (state_q == ST_HOLD && !q_full);
		active   = frame_valid_q && (in_row_q < fh_q);
		row_kept = (out_row_q < th_q) && ({1'b0, in_row_q} == rpos_q);
		col_kept = row_kept && (out_col_q < t_q) && ({1'b0, in_col_q} == cpos_q);
		last_col = out_col_q == t_q - 13'd1;
		row_end  = {1'b0, in_col_q} == fw_q - 13'd1;
	end

	// Step the column and row sample points by quotient plus carried fraction
	always_comb begin
		csum     = {1'b0, cfrac_q} + {1'b0, cr_q};
		cdiff    = csum - t_q;
		cwrap    = csum >= t_q;
		cpos_adv = cpos_q + cq_q + {12'b0, cwrap};
		rsum     = {1'b0, rfrac_q} + {1'b0, rr_q};
		rdiff    = rsum - t_q;
		rwrap    = rsum >= t_q;
		rpos_adv = rpos_q + rq_q + {13'b0, rwrap};
		rem2     = {div_rsp.rem[11:0], 1'b0};
		rdiff0   = rem2 - t_q;
		rwrap0   = rem2 >= t_q;
	end

	// Divider requests: width over target, then height times target over twice width
	always_comb begin
		div_req.start = (state_q == ST_MUL) || (state_q == ST_ROWSTART);
		if (state_q == ST_MUL) begin
			div_req.num = {12'b0, fw_q};
			div_req.den = {1'b0, t_q};
		end else begin
			div_req.num = prod_q;
			div_req.den = {fw_q, 1'b0};
		end
	end

	assign q_push     = step && active && col_kept;
	assign q_item.rgb = cur_rgb;
	assign q_item.eor = last_col;
	assign q_item.eof = last_col && (out_row_q == th_q - 13'd1);

	// Setup sequencer and position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_RUN;
			img_w_q       <= 13'd640;
			img_h_q       <= 13'd480;
			tgt_w_q       <= 13'd80;
			frame_valid_q <= 1'b0;
			fw_q          <= '0;
			fh_q          <= '0;
			t_q           <= '0;
			th_q          <= '0;
			cq_q          <= '0;
			cr_q          <= '0;
			rq_q          <= '0;
			rr_q          <= '0;
			in_col_q      <= '0;
			in_row_q      <= '0;
			out_col_q     <= '0;
			out_row_q     <= '0;
			cpos_q        <= '0;
			cfrac_q       <= '0;
			rpos_q        <= '0;
			rfrac_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					p2a_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_data;
					p2a_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data;
					p2a_pkg::REG_TARGET_WIDTH: tgt_w_q <= cfg_data;
					default: ;
				endcase
			end

			if (step && active) begin
				if (row_end) begin
					// end of input row: column state restarts
					in_col_q  <= '0;
					in_row_q  <= in_row_q + 13'd1;
					out_col_q <= '0;
					cpos_q    <= '0;
					cfrac_q   <= '0;
					if (row_kept) begin
						out_row_q <= out_row_q + 13'd1;
						rpos_q    <= rpos_adv;
						rfrac_q   <= rwrap ? rdiff[11:0] : rsum[11:0];
					end
				end else begin
					if (col_kept) begin
						out_col_q <= out_col_q + 13'd1;
						cpos_q    <= cpos_adv;
						cfrac_q   <= cwrap ? cdiff[11:0] : csum[11:0];
					end
					in_col_q <= in_col_q + 12'd1;
				end
			end

			case (state_q)
				ST_RUN: begin
					if (accept && frame_start) begin
						frame_valid_q <= 1'b1;
						fw_q          <= fw_n;
						fh_q          <= fh_n;
						t_q           <= t_n;
						in_col_q      <= '0;
						in_row_q      <= '0;
						out_col_q     <= '0;
						out_row_q     <= '0;
						cpos_q        <= '0;
						cfrac_q       <= '0;
						rpos_q        <= '0;
						rfrac_q       <= '0;
						state_q       <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_COLDIV;
				end
				ST_COLDIV: begin
					if (div_rsp.done) begin
						cq_q    <= div_rsp.quot[12:0];
						cr_q    <= div_rsp.rem[11:0];
						rq_q    <= {div_rsp.quot[12:0], 1'b0} + {13'b0, rwrap0};
						rr_q    <= rwrap0 ? rdiff0[11:0] : rem2[11:0];
						state_q <= ST_ROWSTART;
					end
				end
				ST_ROWSTART: begin
					state_q <= ST_ROWDIV;
				end
				ST_ROWDIV: begin
					if (div_rsp.done) begin
						th_q    <= div_rsp.quot[12:0];
						state_q <= ST_HOLD;
					end
				end
				ST_HOLD: begin
					if (!q_full) begin
						state_q <= ST_RUN;
					end
				end
				default: state_q <= ST_RUN;
			endcase
		end
	end

	// Hold the frame-start pixel and the setup product
	always_ff @(posedge clk) begin
		if (accept && frame_start) begin
			hold_rgb_q <= pixel_rgb;
		end
		if (state_q == ST_MUL) begin
			prod_q <= prod_full[24:0];
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_COLDIV || state_q == ST_ROWDIV))
		else $error("division result outside a wait state");
	assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> frame_valid_q && (out_col_q < t_q))
		else $error("pixel kept outside a frame");

endmodule

// File: hdl/p2a_back.sv
// Back end: luma, density character, color class and the output register.
module p2a_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_avail,
	input  p2a_pkg::item_t                     q_item,
	output logic                               q_pop,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [p2a_pkg::CHAR_W-1:0]         char_code,
	output logic [p2a_pkg::CLASS_W-1:0]        color_class,
	output logic                               end_of_row,
	output logic                               end_of_frame
);

	// floor(s / 1000) as (s * ceil(2^28 / 1000)) >> 28, exact for s up to 255000
	localparam logic [18:0] LUMA_RECIP = 19'd268436;
	localparam int          LUMA_SHIFT = 28;

	localparam logic [7:0] DARK_LIMIT   = 8'd64;
	localparam logic [7:0] BRIGHT_LIMIT = 8'd192;
	localparam logic [7:0] MIX_LIMIT    = 8'd128;

	localparam logic [3:0] CLS_BLACK     = 4'd0;
	localparam logic [3:0] CLS_WHITE     = 4'd1;
	localparam logic [3:0] CLS_RED_HI    = 4'd2;
	localparam logic [3:0] CLS_RED       = 4'd3;
	localparam logic [3:0] CLS_GREEN_HI  = 4'd4;
	localparam logic [3:0] CLS_GREEN     = 4'd5;
	localparam logic [3:0] CLS_BLUE_HI   = 4'd6;
	localparam logic [3:0] CLS_BLUE      = 4'd7;
	localparam logic [3:0] CLS_YELLOW_HI = 4'd8;
	localparam logic [3:0] CLS_YELLOW    = 4'd9;
	localparam logic [3:0] CLS_MAG_HI    = 4'd10;
	localparam logic [3:0] CLS_MAG       = 4'd11;
	localparam logic [3:0] CLS_CYAN_HI   = 4'd12;
	localparam logic [3:0] CLS_CYAN      = 4'd13;

	// Characters of " .:-=+*#%@"
	localparam logic [6:0] CHAR_SPACE   = 7'd32;
	localparam logic [6:0] CHAR_DOT     = 7'd46;
	localparam logic [6:0] CHAR_COLON   = 7'd58;
	localparam logic [6:0] CHAR_DASH    = 7'd45;
	localparam logic [6:0] CHAR_EQUAL   = 7'd61;
	localparam logic [6:0] CHAR_PLUS    = 7'd43;
	localparam logic [6:0] CHAR_STAR    = 7'd42;
	localparam logic [6:0] CHAR_HASH    = 7'd35;
	localparam logic [6:0] CHAR_PERCENT = 7'd37;
	localparam logic [6:0] CHAR_AT      = 7'd64;

	// Density level floor(luma * 9 / 255) by thresholds ceil(255 k / 9)
	function automatic logic [6:0] density_char(input logic [7:0] luma);
		logic [6:0] ch;
		if (luma >= 8'd255) begin
			ch = CHAR_AT;
		end else if (luma >= 8'd227) begin
			ch = CHAR_PERCENT;
		end else if (luma >= 8'd199) begin
			ch = CHAR_HASH;
		end else if (luma >= 8'd170) begin
			ch = CHAR_STAR;
		end else if (luma >= 8'd142) begin
			ch = CHAR_PLUS;
		end else if (luma >= 8'd114) begin
			ch = CHAR_EQUAL;
		end else if (luma >= 8'd85) begin
			ch = CHAR_DASH;
		end else if (luma >= 8'd57) begin
			ch = CHAR_COLON;
		end else if (luma >= 8'd29) begin
			ch = CHAR_DOT;
		end else begin
			ch = CHAR_SPACE;
		end
		return ch;
	endfunction

	function automatic logic [3:0] color_of(input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		logic [3:0] cls;
		if (r < DARK_LIMIT && g < DARK_LIMIT && b < DARK_LIMIT) begin
			cls = CLS_BLACK;
		end else if (r > BRIGHT_LIMIT && g > BRIGHT_LIMIT && b > BRIGHT_LIMIT) begin
			cls = CLS_WHITE;
		end else if (r > g && r > b) begin
			cls = (r > BRIGHT_LIMIT) ? CLS_RED_HI : CLS_RED;
		end else if (g > r && g > b) begin
			cls = (g > BRIGHT_LIMIT) ? CLS_GREEN_HI : CLS_GREEN;
		end else if (b > r && b > g) begin
			cls = (b > BRIGHT_LIMIT) ? CLS_BLUE_HI : CLS_BLUE;
		end else if (r > MIX_LIMIT && g > MIX_LIMIT) begin
			cls = (r > BRIGHT_LIMIT) ? CLS_YELLOW_HI : CLS_YELLOW;
		end else if (r > MIX_LIMIT && b > MIX_LIMIT) begin
			cls = (r > BRIGHT_LIMIT) ? CLS_MAG_HI : CLS_MAG;
		end else if (g > MIX_LIMIT && b > MIX_LIMIT) begin
			cls = (g > BRIGHT_LIMIT) ? CLS_CYAN_HI : CLS_CYAN;
		end else begin
			cls = CLS_WHITE;
		end
		return cls;
	endfunction

	logic        s1_valid_q;
	logic [17:0] sum_s1;
	logic [3:0]  class_s1;
	logic        eor_s1;
	logic        eof_s1;
	logic        s2_valid_q;
	logic [7:0]  luma_s2;
	logic [3:0]  class_s2;
	logic        eor_s2;
	logic        eof_s2;
	logic        out_valid_q;
	logic [6:0]  char_q;
	logic [3:0]  class_q;
	logic        eor_q;
	logic        eof_q;

	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [17:0] wsum;
	logic [36:0] lprod;
	logic        out_en;
	logic        s2_en;
	logic        s1_en;

	// Each stage moves when the one after it is empty or moving
	always_comb begin
		out_en = !out_valid_q || out_ready;
		s2_en  = !s2_valid_q || out_en;
		s1_en  = !s1_valid_q || s2_en;
		q_pop  = q_avail && s1_en;
		red    = q_item.rgb[23:16];
		green  = q_item.rgb[15:8];
		blue   = q_item.rgb[7:0];
		wsum   = 18'd299 * {10'b0, red} + 18'd587 * {10'b0, green}
			+ 18'd114 * {10'b0, blue};
		lprod  = {19'b0, sum_s1} * {18'b0, LUMA_RECIP};
	end

	// Stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_valid_q <= q_avail;
			end
			if (s2_en) begin
				s2_valid_q <= s1_valid_q;
			end
			if (out_en) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	// Weighted sum, luma, then character lookup
	always_ff @(posedge clk) begin
		if (s1_en && q_avail) begin
			sum_s1   <= wsum;
			class_s1 <= color_of(red, green, blue);
			eor_s1   <= q_item.eor;
			eof_s1   <= q_item.eof;
		end
		if (s2_en && s1_valid_q) begin
			luma_s2  <= lprod[LUMA_SHIFT+7:LUMA_SHIFT];
			class_s2 <= class_s1;
			eor_s2   <= eor_s1;
			eof_s2   <= eof_s1;
		end
		if (out_en && s2_valid_q) begin
			char_q  <= density_char(luma_s2);
			class_q <= class_s2;
			eor_q   <= eor_s2;
			eof_q   <= eof_s2;
		end
	end

	assign out_valid    = out_valid_q;
	assign char_code    = char_q;
	assign color_class  = class_q;
	assign end_of_row   = eor_q;
	assign end_of_frame = eof_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		s2_valid_q && !s2_en |=> s2_valid_q && $stable(luma_s2))
		else $error("stalled luma stage lost its value");

endmodule

// File: hdl/pixel_to_ascii_art_downscaler.sv
// Top level of the pixel to ASCII art downscaler.
//
//   channel   direction  handshake              payload
//   in        in         in_valid / in_ready    pixel_rgb, frame_start
//   out       out        out_valid / out_ready  char_code, color_class, end_of_row, end_of_frame
//   cfg       in         cfg_we                 cfg_index, cfg_data
//
// One pixel per cycle within a frame while the queue has room; a kept pixel passes through
// the queue and the s1, s2 and output registers before it shows up as out_valid. A pixel
// with frame_start holds the input while the shared divider runs two 25-step divisions
// (width over target, height times target over twice width) before it is classified.
// Reset clears all control state; no frame is active until the first frame_start.
// A stalled output fills the four-entry queue, after which the input stalls.
module pixel_to_ascii_art_downscaler (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [p2a_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [p2a_pkg::DIM_W-1:0]          cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [p2a_pkg::RGB_W-1:0]          pixel_rgb,
	input  logic                               frame_start,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [p2a_pkg::CHAR_W-1:0]         char_code,
	output logic [p2a_pkg::CLASS_W-1:0]        color_class,
	output logic                               end_of_row,
	output logic                               end_of_frame
);

	p2a_pkg::div_req_t div_req;
	p2a_pkg::div_rsp_t div_rsp;
	p2a_pkg::item_t    push_item;
	p2a_pkg::item_t    pop_item;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_avail;

	p2a_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	p2a_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.pixel_rgb   (pixel_rgb),
		.frame_start (frame_start),
		.div_req     (div_req),
		.div_rsp     (div_rsp),
		.q_push      (q_push),
		.q_item      (push_item),
		.q_full      (q_full)
	);

	p2a_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (pop_item),
		.avail     (q_avail)
	);

	p2a_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_avail      (q_avail),
		.q_item       (pop_item),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_code    (char_code),
		.color_class  (color_class),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

endmodule

// File: tb/ascii_cell_checker.sv
// Checker that predicts the downscaler's character stream and compares it with the output.
`timescale 1ns / 1ps
module ascii_cell_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [p2a_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [p2a_pkg::DIM_W-1:0]     cfg_data,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic [p2a_pkg::RGB_W-1:0]     pixel_rgb,
	input  logic                          frame_start,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic [p2a_pkg::CHAR_W-1:0]    char_code,
	input  logic [p2a_pkg::CLASS_W-1:0]   color_class,
	input  logic                          end_of_row,
	input  logic                          end_of_frame,
	output int                            mismatches,
	output int                            outstanding
);

	// Channel thresholds of the color sort
	localparam int unsigned DARK_LIMIT   = 64;
	localparam int unsigned MIX_LIMIT    = 128;
	localparam int unsigned BRIGHT_LIMIT = 192;

	typedef enum logic [p2a_pkg::CLASS_W-1:0] {
		CLS_BLACK,
		CLS_WHITE,
		CLS_RED_HI,
		CLS_RED,
		CLS_GREEN_HI,
		CLS_GREEN,
		CLS_BLUE_HI,
		CLS_BLUE,
		CLS_YELLOW_HI,
		CLS_YELLOW,
		CLS_MAGENTA_HI,
		CLS_MAGENTA,
		CLS_CYAN_HI,
		CLS_CYAN
	} color_class_e;

	typedef struct packed {
		logic [p2a_pkg::CHAR_W-1:0] ch;
		color_class_e               cls;
		logic                       eor;
		logic                       eof;
	} ascii_cell_t;

	ascii_cell_t cells_due[$];

	// Register copies and the geometry latched at frame start
	logic [p2a_pkg::DIM_W-1:0] reg_w, reg_h, reg_t;
	int unsigned      frame_w, frame_h, frame_t, rows_out;
	int unsigned      col_in, row_in, col_out, row_out;
	int               err_count = 0;

	function automatic int unsigned fit_dim(input logic [p2a_pkg::DIM_W-1:0] v,
			input int unsigned limit);
		if (v == '0)
			return 1;
		if (v > limit)
			return limit;
		return v;
	endfunction

	// Map a density level 0..9 onto the ramp " .:-=+*#%@"
	function automatic logic [p2a_pkg::CHAR_W-1:0] density_char(input int unsigned level);
		case (level)
			0:       return 7'h20;
			1:       return 7'h2E;
			2:       return 7'h3A;
			3:       return 7'h2D;
			4:       return 7'h3D;
			5:       return 7'h2B;
			6:       return 7'h2A;
			7:       return 7'h23;
			8:       return 7'h25;
			default: return 7'h40;
		endcase
	endfunction

	function automatic color_class_e sort_color(input int unsigned r, g, b);
		if (r < DARK_LIMIT && g < DARK_LIMIT && b < DARK_LIMIT)
			return CLS_BLACK;
		if (r > BRIGHT_LIMIT && g > BRIGHT_LIMIT && b > BRIGHT_LIMIT)
			return CLS_WHITE;
		if (r > g && r > b)
			return (r > BRIGHT_LIMIT) ? CLS_RED_HI : CLS_RED;
		if (g > r && g > b)
			return (g > BRIGHT_LIMIT) ? CLS_GREEN_HI : CLS_GREEN;
		if (b > r && b > g)
			return (b > BRIGHT_LIMIT) ? CLS_BLUE_HI : CLS_BLUE;
		if (r > MIX_LIMIT && g > MIX_LIMIT)
			return (r > BRIGHT_LIMIT) ? CLS_YELLOW_HI : CLS_YELLOW;
		if (r > MIX_LIMIT && b > MIX_LIMIT)
			return (r > BRIGHT_LIMIT) ? CLS_MAGENTA_HI : CLS_MAGENTA;
		if (g > MIX_LIMIT && b > MIX_LIMIT)
			return (g > BRIGHT_LIMIT) ? CLS_CYAN_HI : CLS_CYAN;
		// no dominant channel and no bright pair: falls back to white
		return CLS_WHITE;
	endfunction

	// Advance the raster position by one pixel and queue the character it yields, if any
	function automatic void render_pixel(input logic [p2a_pkg::RGB_W-1:0] rgb, input logic fs);
		int unsigned r, g, b, luma, level;
		logic        row_hit, col_hit, last_col;
		ascii_cell_t due_char;
		if (fs) begin
			frame_w  = fit_dim(reg_w, p2a_pkg::MAX_WIDTH);
			frame_h  = fit_dim(reg_h, p2a_pkg::MAX_HEIGHT);
			frame_t  = (reg_t == '0) ? p2a_pkg::DEFAULT_TARGET : reg_t;
			if (frame_t > frame_w)
				frame_t = frame_w;
			rows_out = (frame_h * frame_t) / (2 * frame_w);
			col_in   = 0;
			row_in   = 0;
			col_out  = 0;
			row_out  = 0;
		end
		// drop pixels before the first frame and past the last input row
		if (frame_t == 0 || row_in >= frame_h)
			return;
		row_hit = (row_out < rows_out) && (row_in == (row_out * 2 * frame_w) / frame_t);
		col_hit = row_hit && (col_out < frame_t) && (col_in == (col_out * frame_w) / frame_t);
		if (col_hit) begin
			r            = rgb[23:16];
			g            = rgb[15:8];
			b            = rgb[7:0];
			luma         = (299 * r + 587 * g + 114 * b) / 1000;
			level        = (luma * 9) / 255;
			if (level > 9)
				level = 9;
			last_col     = (col_out == frame_t - 1);
			due_char.ch  = density_char(level);
			due_char.cls = sort_color(r, g, b);
			due_char.eor = last_col;
			due_char.eof = last_col && (row_out == rows_out - 1);
			cells_due.push_back(due_char);
			col_out++;
		end
		col_in++;
		if (col_in >= frame_w) begin
			col_in = 0;
			row_in++;
			if (row_hit) begin
				row_out++;
				col_out = 0;
			end
		end
	endfunction

	// Track register writes, predict accepted pixels, compare accepted characters
	always @(posedge clk) begin : watch
		ascii_cell_t want;
		if (!arst_n) begin
			reg_w    = 13'd640;
			reg_h    = 13'd480;
			reg_t    = p2a_pkg::DEFAULT_TARGET;
			frame_w  = 0;
			frame_h  = 0;
			frame_t  = 0;
			rows_out = 0;
			col_in   = 0;
			row_in   = 0;
			col_out  = 0;
			row_out  = 0;
			cells_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					p2a_pkg::REG_IMAGE_WIDTH:  reg_w = cfg_data;
					p2a_pkg::REG_IMAGE_HEIGHT: reg_h = cfg_data;
					p2a_pkg::REG_TARGET_WIDTH: reg_t = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				render_pixel(pixel_rgb, frame_start);
			if (out_valid && out_ready) begin
				if (cells_due.size() == 0) begin
					$error("char_code: expected nothing, got 0x%02h", char_code);
					err_count++;
				end else begin
					want = cells_due.pop_front();
					if (char_code !== want.ch) begin
						$error("char_code: expected 0x%02h, got 0x%02h", want.ch, char_code);
						err_count++;
					end
					if (color_class !== want.cls) begin
						$error("color_class: expected %0d, got %0d", want.cls, color_class);
						err_count++;
					end
					if (end_of_row !== want.eor) begin
						$error("end_of_row: expected %0b, got %0b", want.eor, end_of_row);
						err_count++;
					end
					if (end_of_frame !== want.eof) begin
						$error("end_of_frame: expected %0b, got %0b", want.eof, end_of_frame);
						err_count++;
					end
				end
			end
		end
		mismatches  <= err_count;
		outstanding <= cells_due.size();
	end

endmodule

// File: tb/tb_pixel_to_ascii_art_downscaler.sv
// Stimulus, pacing and verdict for the pixel to ASCII art downscaler.
`timescale 1ns / 1ps
module tb_pixel_to_ascii_art_downscaler;

	localparam int RANDOM_ITEMS  = 1250;
	localparam int SETTLE_CYCLES = 80;
	localparam int FRAME_CAP     = 60;

	// One pixel of each color class, black and white at the extremes
	localparam logic [13:0][p2a_pkg::RGB_W-1:0] SWATCHES = {
		24'h000000, 24'hFFFFFF, 24'hFF0000, 24'h800000, 24'h00FF00, 24'h008000, 24'h0000FF,
		24'h000080, 24'hFFFF00, 24'hA0A000, 24'hFF00FF, 24'hA000A0, 24'h00FFFF, 24'h00A0A0
	};

	typedef enum int {PACE_FREE, PACE_SRC_IDLE, PACE_SINK_STALL, PACE_BOTH} pace_e;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          cfg_we;
	logic [p2a_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [p2a_pkg::DIM_W-1:0]     cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [p2a_pkg::RGB_W-1:0]     pixel_rgb;
	logic                          frame_start;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [p2a_pkg::CHAR_W-1:0]    char_code;
	logic [p2a_pkg::CLASS_W-1:0]   color_class;
	logic                          end_of_row;
	logic                          end_of_frame;
	int                            mismatches;
	int                            outstanding;
	int                            src_idle_pct = 0;
	int                            sink_stall_pct = 0;
	int                            items_sent = 0;

	pixel_to_ascii_art_downscaler dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_rgb    (pixel_rgb),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_code    (char_code),
		.color_class  (color_class),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame)
	);

	ascii_cell_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_rgb    (pixel_rgb),
		.frame_start  (frame_start),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.char_code    (char_code),
		.color_class  (color_class),
		.end_of_row   (end_of_row),
		.end_of_frame (end_of_frame),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Stall the output at the current rate
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
	end

	function automatic logic [7:0] pick_channel();
		case ($urandom_range(0, 5))
			0: return 8'($urandom_range(0, 63));
			1: return 8'($urandom_range(193, 255));
			2: begin
				// sit on or right beside a threshold of the color sort
				case ($urandom_range(0, 5))
					0:       return 8'd63;
					1:       return 8'd64;
					2:       return 8'd128;
					3:       return 8'd129;
					4:       return 8'd192;
					default: return 8'd193;
				endcase
			end
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Random pixel, with tied channels now and then to reach the mixed classes
	function automatic logic [p2a_pkg::RGB_W-1:0] pick_pixel();
		logic [7:0] r, g, b;
		r = pick_channel();
		g = pick_channel();
		b = pick_channel();
		case ($urandom_range(0, 7))
			0:       g = r;
			1:       b = r;
			2:       b = g;
			default: ;
		endcase
		return {r, g, b};
	endfunction

	task automatic set_pace(input pace_e pace);
		case (pace)
			PACE_FREE: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			PACE_SRC_IDLE: begin
				src_idle_pct   = 70;
				sink_stall_pct = 0;
			end
			PACE_SINK_STALL: begin
				src_idle_pct   = 0;
				sink_stall_pct = 70;
			end
			default: begin
				src_idle_pct   = 21;
				sink_stall_pct = 21;
			end
		endcase
	endtask

	// Write all three registers on consecutive edges
	task automatic program_regs(input logic [p2a_pkg::DIM_W-1:0] w, h, t);
		cfg_we    <= 1'b1;
		cfg_index <= p2a_pkg::REG_IMAGE_WIDTH;
		cfg_data  <= w;
		@(posedge clk);
		cfg_index <= p2a_pkg::REG_IMAGE_HEIGHT;
		cfg_data  <= h;
		@(posedge clk);
		cfg_index <= p2a_pkg::REG_TARGET_WIDTH;
		cfg_data  <= t;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Offer one pixel request, with an optional idle gap, and hold it until taken
	task automatic push_pixel(input logic [p2a_pkg::RGB_W-1:0] rgb, input logic fs);
		if ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(0, 99) < src_idle_pct);
		end
		in_valid    <= 1'b1;
		pixel_rgb   <= rgb;
		frame_start <= fs;
		do
			@(posedge clk);
		while (!in_ready);
	endtask

	// Hold the input idle until every predicted character is out, then let the block settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register setting followed by a few frames, some cut short by a new frame start
	task automatic run_random_phase();
		int unsigned w_reg, h_reg, t_reg, t_eff, span, fw, fh, len;
		bit          cut;
		case ($urandom_range(0, 9))
			0: begin
				w_reg = $urandom_range(4000, 8191);
				h_reg = $urandom_range(4000, 8191);
				case ($urandom_range(0, 2))
					0:       t_reg = 0;
					1:       t_reg = 8191;
					default: t_reg = $urandom_range(1, 8191);
				endcase
			end
			1: begin
				w_reg = $urandom_range(0, 3);
				h_reg = $urandom_range(0, 3);
				t_reg = $urandom_range(0, 4);
			end
			default: begin
				// small frames, mostly with enough rows that some output rows exist
				w_reg = $urandom_range(1, 12);
				t_eff = $urandom_range(0, 1) ? w_reg : $urandom_range(1, w_reg);
				span  = (2 * w_reg + t_eff - 1) / t_eff;
				h_reg = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 12)
				                                    : span + $urandom_range(0, 3);
				if (t_eff == w_reg && $urandom_range(0, 2) == 0)
					t_reg = $urandom_range(0, 1) ? 0 : $urandom_range(w_reg, 8191);
				else
					t_reg = t_eff;
			end
		endcase
		program_regs(p2a_pkg::DIM_W'(w_reg), p2a_pkg::DIM_W'(h_reg), p2a_pkg::DIM_W'(t_reg));
		fw = (w_reg == 0) ? 1 : ((w_reg > p2a_pkg::MAX_WIDTH) ? p2a_pkg::MAX_WIDTH : w_reg);
		fh = (h_reg == 0) ? 1 : ((h_reg > p2a_pkg::MAX_HEIGHT) ? p2a_pkg::MAX_HEIGHT : h_reg);
		repeat ($urandom_range(1, 3)) begin
			len = fw * fh;
			cut = (len > FRAME_CAP) || ($urandom_range(0, 4) == 0);
			if (cut)
				len = $urandom_range(1, (len > FRAME_CAP) ? FRAME_CAP : len);
			for (int i = 0; i < len; i++)
				push_pixel(pick_pixel(), i == 0);
			items_sent += len;
			// trail a complete frame with pixels that must be ignored
			if (!cut && $urandom_range(0, 3) == 0)
				repeat ($urandom_range(1, 3)) push_pixel(pick_pixel(), 1'b0);
		end
		drain();
	endtask

	initial begin
		int phase;
		cfg_we      <= 1'b0;
		cfg_index   <= p2a_pkg::REG_IMAGE_WIDTH;
		cfg_data    <= '0;
		in_valid    <= 1'b0;
		pixel_rgb   <= '0;
		frame_start <= 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_pace(PACE_FREE);

		// pixels before the first frame start yield nothing
		push_pixel(pick_pixel(), 1'b0);
		push_pixel(pick_pixel(), 1'b0);
		drain();

		// one output row covering every color class; target 0 clamps to the width
		program_regs(13'd14, 13'd2, 13'd0);
		for (int i = 0; i < 14; i++)
			push_pixel(SWATCHES[i], i == 0);
		push_pixel(24'h505050, 1'b0);
		drain();

		// zero width reads as one, oversized height and target saturate
		program_regs(13'd0, 13'h1FFF, 13'h1FFF);
		for (int i = 0; i < 4; i++)
			push_pixel(pick_pixel(), i == 0);
		drain();

		// frame with no output rows
		program_regs(13'h1FFF, 13'd0, 13'd1);
		push_pixel(24'hFFFFFF, 1'b1);
		push_pixel(24'h000000, 1'b0);
		drain();

		// widest frame, cut short after two characters
		program_regs(13'h1FFF, 13'h1FFF, 13'h1FFF);
		push_pixel(24'hFFFFFF, 1'b1);
		push_pixel(24'h000000, 1'b0);
		drain();

		// random phases, rotating through the pacing modes
		phase = 0;
		while (items_sent < RANDOM_ITEMS) begin
			set_pace(pace_e'(phase % 4));
			run_random_phase();
			phase++;
		end

		if (mismatches == 0 && outstanding == 0)
			$display("[pixel_to_ascii_art_downscaler] OK");
		else
			$display("[pixel_to_ascii_art_downscaler] ERROR");
		$finish;
	end

	// Hang guard
	initial begin
		#8_000_000;
		$display("[pixel_to_ascii_art_downscaler] ERROR");
		$finish;
	end

endmodule

// File: sim.f
hdl/p2a_pkg.sv
hdl/p2a_div.sv
hdl/p2a_queue.sv
hdl/p2a_front.sv
hdl/p2a_back.sv
hdl/pixel_to_ascii_art_downscaler.sv
tb/ascii_cell_checker.sv
tb/tb_pixel_to_ascii_art_downscaler.sv
